>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AFFA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define AFFA_ASSERT_MSG(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`else
`define AFFA_ASSERT(lbl, clk, rst, prop)
`define AFFA_ASSERT_MSG(lbl, clk, rst, prop, msg)
`endif
`endif

>>> hdl/affa_pkg.sv
package affa_pkg;

   localparam int unsigned SIZE_W = 25;
   localparam int unsigned BASE_W = 32;
   localparam int unsigned CAP_W  = 33;
   localparam int unsigned CAND_W = 34;

   localparam logic [SIZE_W-1:0] MAX_SINGLE_BYTES = 25'd16777216;
   localparam logic [CAP_W-1:0]  CAP_RESET        = 33'd67108864;
   localparam logic [CAP_W-1:0]  ADDR_LIMIT       = 33'h1_0000_0000;

   typedef enum logic [2:0] {
      ST_GRANTED   = 3'd0,
      ST_BAD_SIZE  = 3'd1,
      ST_NO_SPACE  = 3'd2,
      ST_FREED     = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PRE,
      S_FIT,
      S_ISSUE,
      S_EVAL,
      S_RESP
   } state_type;

   typedef struct packed {
      logic       load;
      logic       next;
      logic       advance;
      logic       write;
      logic       clear;
      logic       finish;
      status_type code;
   } cmd_type;

   typedef struct packed {
      logic is_free;
      logic bad_size;
      logic full;
      logic fits;
      logic hit;
      logic last;
   } stat_type;

   // smallest power of two not below size
   function automatic logic [SIZE_W-1:0] next_pow2(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] res;
      res = {1'b1, {(SIZE_W-1){1'b0}}};
      for (int k = SIZE_W-1; k >= 0; k--) begin
         if ((SIZE_W'(1) << k) >= size) begin
            res = SIZE_W'(1) << k;
         end
      end
      return res;
   endfunction

endpackage

>>> hdl/affa_ram.sv
module affa_ram
   #(parameter int WIDTH = 57,
     parameter int DEPTH = 64,
     parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1)
   (input  logic             clock,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/affa_ctrl.sv
module affa_ctrl
   import affa_pkg::*;
   (input  logic     clock,
    input  logic     reset,
    input  logic     req_tvalid,
    output logic     req_tready,
    output logic     rsp_tvalid,
    input  logic     rsp_tready,
    input  stat_type stat,
    output cmd_type  cmd);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_PRE;
         end
         S_PRE: begin
            if (stat.is_free) state_in = S_ISSUE;
            else if (stat.bad_size || stat.full) state_in = S_RESP;
            else state_in = S_FIT;
         end
         S_FIT: begin
            state_in = stat.fits ? S_ISSUE : S_RESP;
         end
         S_ISSUE: state_in = S_EVAL;
         S_EVAL: begin
            if (stat.hit) state_in = stat.is_free ? S_RESP : S_FIT;
            else if (stat.last) state_in = S_RESP;
            else state_in = S_ISSUE;
         end
         S_RESP: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '{load: 1'b0, next: 1'b0, advance: 1'b0, write: 1'b0, clear: 1'b0,
              finish: 1'b0, code: ST_GRANTED};
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         S_PRE: begin
            if (!stat.is_free) begin
               if (stat.bad_size) begin
                  cmd.finish = 1'b1;
                  cmd.code   = ST_BAD_SIZE;
               end else if (stat.full) begin
                  cmd.finish = 1'b1;
                  cmd.code   = ST_NO_SPACE;
               end
            end
         end
         S_FIT: begin
            if (!stat.fits) begin
               cmd.finish = 1'b1;
               cmd.code   = ST_NO_SPACE;
            end
         end
         S_ISSUE: ;
         S_EVAL: begin
            if (stat.hit) begin
               if (stat.is_free) begin
                  cmd.clear  = 1'b1;
                  cmd.finish = 1'b1;
                  cmd.code   = ST_FREED;
               end else begin
                  cmd.advance = 1'b1;
               end
            end else if (stat.last) begin
               cmd.finish = 1'b1;
               if (stat.is_free) begin
                  cmd.code = ST_NOT_FOUND;
               end else begin
                  cmd.write = 1'b1;
                  cmd.code  = ST_GRANTED;
               end
            end else begin
               cmd.next = 1'b1;
            end
         end
         S_RESP: rsp_tvalid = 1'b1;
         default: ;
      endcase
   end

endmodule

>>> hdl/affa_dp.sv
module affa_dp
   import affa_pkg::*;
   #(parameter int MAX_BLOCKS = 64)
   (input  logic                clock,
    input  logic                reset,
    input  logic                csr_wr_en,
    input  logic [CAP_W-1:0]    csr_wr_data,
    input  logic                in_kind,
    input  logic [SIZE_W-1:0]   in_size,
    input  logic [BASE_W-1:0]   in_base,
    input  cmd_type             cmd,
    output stat_type            stat,
    output status_type          out_status,
    output logic [BASE_W-1:0]   out_base);

   localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int ENTRY_W = BASE_W + SIZE_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BLOCKS - 1);

   logic                  kind_ff;
   logic [SIZE_W-1:0]     size_ff;
   logic [BASE_W-1:0]     base_ff;
   logic [SIZE_W-1:0]     align_ff;
   logic [CAND_W-1:0]     cand_ff, cand_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [MAX_BLOCKS-1:0] valid_ff;
   logic [CAP_W-1:0]      cap_ff;
   status_type            status_ff;
   logic [BASE_W-1:0]     gbase_ff;

   logic [ENTRY_W-1:0]    rd_data;
   logic [BASE_W-1:0]     ent_base;
   logic [SIZE_W-1:0]     ent_size;
   logic [CAP_W-1:0]      ent_end;
   logic [CAND_W:0]       cand_end;
   logic [CAP_W-1:0]      limit;
   logic [CAND_W-1:0]     align_m1;
   logic [CAND_W-1:0]     rounded;
   logic [IDX_W-1:0]      free_slot;
   logic [SIZE_W-1:0]     load_align;
   logic                  overlap;
   logic                  match;

   affa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_ram (
      .clock  (clock),
      .wr_en  (cmd.write),
      .wr_addr(free_slot),
      .wr_data({cand_ff[BASE_W-1:0], size_ff}),
      .rd_addr(idx_ff),
      .rd_data(rd_data));

   assign ent_base   = rd_data[ENTRY_W-1:SIZE_W];
   assign ent_size   = rd_data[SIZE_W-1:0];
   assign ent_end    = {1'b0, ent_base} + {{(CAP_W-SIZE_W){1'b0}}, ent_size};
   assign cand_end   = {1'b0, cand_ff} + {{(CAND_W+1-SIZE_W){1'b0}}, size_ff};
   assign limit      = (cap_ff >= ADDR_LIMIT) ? ADDR_LIMIT : cap_ff;
   assign align_m1   = {{(CAND_W-SIZE_W){1'b0}}, align_ff} - CAND_W'(1);
   assign rounded    = ({1'b0, ent_end} + align_m1) & ~align_m1;
   assign load_align = next_pow2(in_size);

   assign overlap = ({1'b0, cand_ff} < {2'b0, ent_end}) &&
                    ({3'b0, ent_base} < cand_end);
   assign match   = (ent_base == base_ff) && (ent_size == size_ff);

   always_comb begin
      free_slot = '0;
      for (int i = MAX_BLOCKS-1; i >= 0; i--) begin
         if (!valid_ff[i]) free_slot = IDX_W'(i);
      end
   end

   assign stat.is_free  = kind_ff;
   assign stat.bad_size = (size_ff == '0) || (size_ff > MAX_SINGLE_BYTES);
   assign stat.full     = &valid_ff;
   assign stat.fits     = cand_end <= {2'b0, limit};
   assign stat.hit      = valid_ff[idx_ff] && (kind_ff ? match : overlap);
   assign stat.last     = idx_ff == LAST_IDX;

   always_comb begin
      idx_in  = idx_ff;
      cand_in = cand_ff;
      if (cmd.load) begin
         idx_in  = '0;
         cand_in = {{(CAND_W-SIZE_W){1'b0}}, load_align};
      end else if (cmd.advance) begin
         idx_in  = '0;
         cand_in = rounded;
      end else if (cmd.next) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         cap_ff   <= CAP_RESET;
      end else begin
         if (csr_wr_en) cap_ff <= csr_wr_data;
         if (cmd.write) valid_ff[free_slot] <= 1'b1;
         if (cmd.clear) valid_ff[idx_ff] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      cand_ff <= cand_in;
      if (cmd.load) begin
         kind_ff  <= in_kind;
         size_ff  <= in_size;
         base_ff  <= in_base;
         align_ff <= load_align;
      end
      if (cmd.finish) begin
         status_ff <= cmd.code;
         gbase_ff  <= (cmd.code == ST_GRANTED) ? cand_ff[BASE_W-1:0] : '0;
      end
   end

   assign out_status = status_ff;
   assign out_base   = gbase_ff;

endmodule

>>> hdl/aligned_first_fit_allocator_unit.sv
// Aligned first-fit allocator.
// req channel: tuser[0] is the kind (0 allocate, 1 free); tdata carries the
// size in bytes and, for a free, the base of the block to release.
// rsp channel: one item per request, tuser the status code, tdata the
// granted base (zero unless granted).
// csr port: writing csr_wr_data sets the managed capacity in bytes.
// One request is handled at a time; req_tready is high only while idle.
// A free scans the block table entry by entry, each entry passing an issue
// and an evaluate state. An allocate scans the table once per candidate
// base; each blocking entry moves the candidate past it, giving at most
// MAX_BLOCKS+1 scans. The registered read of the table memory sets the
// issue and evaluate states per entry. For an allocate, rejected sizes
// and a full table answer from the pre-check without a scan.
// Reset empties the table and loads a capacity of 64 MiB.
// A result is held in the output register until rsp_tready; no new
// request is taken until then.
`include "assert_macros.svh"
module aligned_first_fit_allocator_unit
   import affa_pkg::*;
   #(parameter int MAX_BLOCKS = 64)
   (input  logic        clock,
    input  logic        reset,
    input  logic        req_tvalid,
    output logic        req_tready,
    input  logic [63:0] req_tdata,   // req_size[24:0], req_base[56:25], zero pad
    input  logic        req_tuser,   // kind
    output logic        rsp_tvalid,
    input  logic        rsp_tready,
    output logic [31:0] rsp_tdata,   // granted_base[31:0]
    output logic [2:0]  rsp_tuser,   // status[2:0]
    input  logic        csr_wr_en,
    input  logic [32:0] csr_wr_data);

   cmd_type    cmd;
   stat_type   stat;
   status_type out_status;

   affa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .stat      (stat),
      .cmd       (cmd));

   affa_dp #(.MAX_BLOCKS(MAX_BLOCKS)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .in_kind    (req_tuser),
      .in_size    (req_tdata[24:0]),
      .in_base    (req_tdata[56:25]),
      .cmd        (cmd),
      .stat       (stat),
      .out_status (out_status),
      .out_base   (rsp_tdata));

   assign rsp_tuser = out_status;

   `AFFA_ASSERT(a_no_overlap_hs, clock, reset, !(req_tready && rsp_tvalid))
   `AFFA_ASSERT_MSG(a_base_zero, clock, reset,
      (rsp_tvalid && rsp_tuser != ST_GRANTED) |-> rsp_tdata == '0, "base not zero")
   `AFFA_ASSERT(a_busy_after_accept, clock, reset, (req_tvalid && req_tready) |=> !req_tready)

endmodule
